[design/rmst_pkg.sv]
// ---------------------------------------------------------------------------
// rmst_pkg: shared types and constants for the range minimum segment tree
// Field widths, operation codes, the infinity value and value helpers.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rmst_pkg;

  // Item field widths
  localparam int unsigned OP_W  = 2;
  localparam int unsigned POS_W = 10;
  localparam int unsigned END_W = 11;
  localparam int unsigned VAL_W = 61;

  // Padded bus widths
  localparam int unsigned S_TDATA_W = 88;
  localparam int unsigned M_TDATA_W = 64;

  // Default tree size
  localparam int unsigned LEAVES_DEFAULT = 1024;

  // Infinity marker, also the clamp bound
  localparam logic signed [VAL_W-1:0] INF_VAL = 61'sd1000000000000000000;

  // Operation codes
  typedef enum logic [OP_W-1:0] {
    OP_UPDATE = 2'd0,
    OP_QUERY  = 2'd1,
    OP_READ   = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef logic signed [VAL_W-1:0] val_t;

  // Signed minimum
  function automatic val_t val_min(input val_t a, input val_t b);
    return (b < a) ? b : a;
  endfunction

  // Clamp to [-INF, INF]
  function automatic val_t val_clamp(input val_t v);
    val_t r;
    r = v;
    if (v > INF_VAL) r = INF_VAL;
    if (v < -INF_VAL) r = -INF_VAL;
    return r;
  endfunction

endpackage

`default_nettype wire

[design/rmst_ram.sv]
// ---------------------------------------------------------------------------
// rmst_ram: tree node storage
// Simple dual-port RAM, one write and one read port, registered read data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rmst_ram
  import rmst_pkg::*;
#(
  parameter int unsigned DEPTH = 2 * LEAVES_DEFAULT,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  wire logic          clk_i,
  input  wire logic          wr_en_i,
  input  wire logic [AW-1:0] wr_addr_i,
  input  wire val_t          wr_data_i,
  input  wire logic          rd_en_i,
  input  wire logic [AW-1:0] rd_addr_i,
  output      val_t          rd_data_o
);

  val_t mem [DEPTH];
  val_t rd_data_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // Read port, registered read data
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

[design/range_minimum_segment_tree.sv]
// ---------------------------------------------------------------------------
// range_minimum_segment_tree: range minimum over a segment tree in RAM
// Updates a leaf and its ancestors, answers half-open range minimum
// queries and point reads.
// ---------------------------------------------------------------------------
// Usage:
//   Input stream (s_axis): tuser carries the operation (update, range query,
//   point read; the unused code is dropped), tdata the leaf index, the range
//   end and the value to store. One transfer is taken when the block is idle.
//   Output stream (m_axis): one transfer per query or point read with the
//   minimum, 1e18 for an empty range. Updates give no output.
//   An update walks leaf to root; per level it writes the node and reads
//   its sibling, then forms the parent value from the two. A query walks
//   both range ends up the tree, left edge then right edge per level; a
//   point read is one node read. All of it is bound by the single read
//   port of the node RAM, so items run one at a time.
//   After reset the block sweeps the node RAM to 1e18 and holds
//   s_axis_tready low meanwhile.
//   The result sits in an output register; the next item is taken while it
//   waits. A new result waits in the final step until that register frees.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module range_minimum_segment_tree
  import rmst_pkg::*;
#(
  parameter int unsigned LEAVES = LEAVES_DEFAULT
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 s_axis_tvalid,
  output      logic                 s_axis_tready,
  // [9:0] position, [20:10] range_end, [81:21] new_value, [87:82] zero
  input  wire logic [S_TDATA_W-1:0] s_axis_tdata,
  // [1:0] opcode
  input  wire logic [OP_W-1:0]      s_axis_tuser,
  output      logic                 m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  // [60:0] min_value, [63:61] zero
  output      logic [M_TDATA_W-1:0] m_axis_tdata
);

  // Node address and walk index widths
  localparam int unsigned DEPTH = 2 * LEAVES;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned LMAX  = (LEAVES > 2 ** POS_W) ? 2 * LEAVES : LEAVES + 2 ** POS_W;
  localparam int unsigned LW    = $clog2(LMAX + 1);

  // Sequencer states
  localparam logic [2:0] ST_CLR  = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_UPW  = 3'd2;
  localparam logic [2:0] ST_UPR  = 3'd3;
  localparam logic [2:0] ST_QL   = 3'd4;
  localparam logic [2:0] ST_QR   = 3'd5;
  localparam logic [2:0] ST_FIN  = 3'd6;

  logic [2:0]    state_q, state_d;
  logic [AW-1:0] clr_addr_q, clr_addr_d;
  logic [AW-1:0] idx_q, idx_d;
  val_t          cur_q, cur_d;
  logic [LW-1:0] l_q, l_d;
  logic [LW-1:0] r_q, r_d;
  val_t          res_q, res_d;
  logic          pend_q, pend_d;
  logic          out_vld_q, out_vld_d;
  val_t          out_q, out_d;

  // Input fields
  op_e            in_op;
  logic [POS_W-1:0] in_pos;
  logic [END_W-1:0] in_end;
  val_t           in_val;
  logic [LW-1:0]  pos_ext;
  logic [LW-1:0]  hi_sat;
  logic           s_acc;

  // RAM ports
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  val_t          wr_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  val_t          rd_data;

  logic [LW-1:0] r_dec;
  val_t          fin_val;
  logic          out_free;

  assign in_op  = op_e'(s_axis_tuser);
  assign in_pos = s_axis_tdata[POS_W-1:0];
  assign in_end = s_axis_tdata[POS_W+END_W-1:POS_W];
  assign in_val = s_axis_tdata[POS_W+END_W+VAL_W-1:POS_W+END_W];

  assign pos_ext = LW'(in_pos);
  assign hi_sat  = (LW'(in_end) > LW'(LEAVES)) ? LW'(LEAVES) : LW'(in_end);

  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_acc         = s_axis_tvalid && s_axis_tready;

  assign r_dec    = r_q - LW'(1);
  assign fin_val  = pend_q ? val_min(res_q, rd_data) : res_q;
  assign out_free = !out_vld_q || m_axis_tready;

  // Sequencer: one item at a time, so RAM accesses of two items never overlap
  always_comb begin
    state_d    = state_q;
    clr_addr_d = clr_addr_q;
    idx_d      = idx_q;
    cur_d      = cur_q;
    l_d        = l_q;
    r_d        = r_q;
    res_d      = res_q;
    out_d      = out_q;
    out_vld_d  = out_vld_q;
    wr_en      = 1'b0;
    wr_addr    = idx_q;
    wr_data    = cur_q;
    rd_en      = 1'b0;
    rd_addr    = idx_q ^ AW'(1);

    // fold a pending node read into the running minimum
    if (pend_q) begin
      res_d = val_min(res_q, rd_data);
    end

    // output register drains
    if (out_vld_q && m_axis_tready) begin
      out_vld_d = 1'b0;
    end

    case (state_q)
      ST_CLR: begin
        wr_en      = 1'b1;
        wr_addr    = clr_addr_q;
        wr_data    = INF_VAL;
        clr_addr_d = clr_addr_q + AW'(1);
        if (clr_addr_q == AW'(DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (s_acc) begin
          case (in_op)
            OP_UPDATE: begin
              if (pos_ext < LW'(LEAVES)) begin
                idx_d   = AW'(pos_ext + LW'(LEAVES));
                cur_d   = val_clamp(in_val);
                state_d = ST_UPW;
              end
            end
            OP_QUERY: begin
              l_d     = pos_ext + LW'(LEAVES);
              r_d     = hi_sat + LW'(LEAVES);
              res_d   = INF_VAL;
              state_d = ST_QL;
            end
            OP_READ: begin
              res_d   = INF_VAL;
              state_d = ST_FIN;
              if (pos_ext < LW'(LEAVES)) begin
                rd_en   = 1'b1;
                rd_addr = AW'(pos_ext + LW'(LEAVES));
              end
            end
            default: begin
            end
          endcase
        end
      end
      // write the node, fetch its sibling unless at the root
      ST_UPW: begin
        wr_en = 1'b1;
        if (idx_q == AW'(1)) begin
          state_d = ST_IDLE;
        end else begin
          rd_en   = 1'b1;
          state_d = ST_UPR;
        end
      end
      // parent value from node and sibling
      ST_UPR: begin
        cur_d   = val_min(cur_q, rd_data);
        idx_d   = idx_q >> 1;
        state_d = ST_UPW;
      end
      // left edge of the walk
      ST_QL: begin
        if (l_q < r_q) begin
          if (l_q[0]) begin
            rd_en   = 1'b1;
            rd_addr = l_q[AW-1:0];
            l_d     = l_q + LW'(1);
          end
          state_d = ST_QR;
        end else begin
          state_d = ST_FIN;
        end
      end
      // right edge, then one level up
      ST_QR: begin
        if (r_q[0]) begin
          rd_en   = 1'b1;
          rd_addr = r_dec[AW-1:0];
          r_d     = r_dec >> 1;
        end else begin
          r_d = r_q >> 1;
        end
        l_d     = l_q >> 1;
        state_d = ST_QL;
      end
      // hand the result to the output register
      ST_FIN: begin
        if (out_free) begin
          out_d     = fin_val;
          out_vld_d = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // a read in any state but the update walk feeds the running minimum
  assign pend_d = rd_en && (state_q != ST_UPW);

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLR;
      clr_addr_q <= '0;
      pend_q     <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      clr_addr_q <= clr_addr_d;
      pend_q     <= pend_d;
      out_vld_q  <= out_vld_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    cur_q <= cur_d;
    l_q   <= l_d;
    r_q   <= r_d;
    res_q <= res_d;
    out_q <= out_d;
  end

  rmst_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{(M_TDATA_W - VAL_W){1'b0}}, out_q};

`ifndef NO_ASSERTIONS
  // no item is taken while the clearing sweep runs
  a_no_acc_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLR) |-> !s_axis_tready)
    else $error("item accepted during clearing sweep");

  // the update walk never writes the node it reads in the same cycle
  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_en && rd_en) |-> (wr_addr != rd_addr))
    else $error("read and write of the same node in one cycle");

  // a new result only comes out of the final step
  a_result_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_d && !out_vld_q) |-> (state_q == ST_FIN))
    else $error("result produced outside the final step");

  // the update walk stops at the root and never reaches node zero
  a_walk_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_UPW) || (state_q == ST_UPR)) |-> (idx_q != '0))
    else $error("update walk reached node zero");

  // a folded read was issued in the previous cycle
  a_pend_follows_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> $past(rd_en))
    else $error("pending read without a RAM read");
`endif

endmodule

`default_nettype wire

[dv/testbench.sv]
// ---------------------------------------------------------------------------
// testbench: self-checking bench for range_minimum_segment_tree
// Drives updates, range minimum queries, point reads and the unused code
// through the input stream. A shadow copy of the segment tree predicts
// every minimum, and each output transfer is checked in order.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import rmst_pkg::*;

  localparam int unsigned TREE_LEAVES = LEAVES_DEFAULT;
  localparam int unsigned RANDOM_ITEMS = 1200;

  // Shadow tree and the minima still owed by the block
  class range_min_book;
    val_t        shadow_nodes[2*TREE_LEAVES];
    val_t        due_minima[$];
    int unsigned fails;
    int unsigned updates, queries, empties, reads, dropped, checked;

    function new();
      foreach (shadow_nodes[i]) shadow_nodes[i] = INF_VAL;
    endfunction

    // Leaf write, then recompute every ancestor up to the root
    function void write_leaf(int unsigned pos, val_t v);
      int unsigned n;
      n = pos + TREE_LEAVES;
      if (v > INF_VAL) v = INF_VAL;
      else if (v < -INF_VAL) v = -INF_VAL;
      shadow_nodes[n] = v;
      while (n > 1) begin
        n = n >> 1;
        shadow_nodes[n] = (shadow_nodes[2*n+1] < shadow_nodes[2*n]) ?
                          shadow_nodes[2*n+1] : shadow_nodes[2*n];
      end
    endfunction

    // Bottom-up walk over [lo, hi)
    function val_t span_min(int unsigned lo, int unsigned hi);
      val_t        best;
      int unsigned l, r;
      best = INF_VAL;
      if (hi > TREE_LEAVES) hi = TREE_LEAVES;
      if (lo >= hi) begin
        empties++;
        return INF_VAL;
      end
      l = lo + TREE_LEAVES;
      r = hi + TREE_LEAVES;
      while (l < r) begin
        if (l[0]) begin
          if (shadow_nodes[l] < best) best = shadow_nodes[l];
          l++;
        end
        if (r[0]) begin
          r--;
          if (shadow_nodes[r] < best) best = shadow_nodes[r];
        end
        l = l >> 1;
        r = r >> 1;
      end
      return best;
    endfunction

    // Accepted input transfer
    function void note_item(op_e op, logic [POS_W-1:0] pos, logic [END_W-1:0] stop,
                            val_t v);
      case (op)
        OP_UPDATE: begin
          updates++;
          if (pos < TREE_LEAVES) write_leaf(pos, v);
        end
        OP_QUERY: begin
          queries++;
          due_minima.push_back(span_min(pos, stop));
        end
        OP_READ: begin
          reads++;
          due_minima.push_back((pos < TREE_LEAVES) ? shadow_nodes[pos + TREE_LEAVES]
                                                   : INF_VAL);
        end
        default: dropped++;
      endcase
    endfunction

    // Accepted output transfer
    function void check_result(logic [M_TDATA_W-1:0] word);
      val_t want;
      if (due_minima.size() == 0) begin
        $error("min_value: no result expected, got %0d", $signed(word[VAL_W-1:0]));
        fails++;
        return;
      end
      want = due_minima.pop_front();
      checked++;
      if (word[VAL_W-1:0] !== want) begin
        $error("min_value: expected %0d, got %0d", want, $signed(word[VAL_W-1:0]));
        fails++;
      end
      if (word[M_TDATA_W-1:VAL_W] !== '0) begin
        $error("tdata padding: expected 0, got %0h", word[M_TDATA_W-1:VAL_W]);
        fails++;
      end
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata = '0;
  logic [OP_W-1:0]      s_axis_tuser = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;

  bit                   calm = 1'b0;
  range_min_book        book = new();

  range_minimum_segment_tree u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Output side back-pressure
  always @(posedge clk_i) begin
    m_axis_tready <= calm ? 1'b1 : ($urandom_range(99) >= 15);
  end

  // Transfer monitor; checks come first since a result always predates
  // the input taken at the same edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) book.check_result(m_axis_tdata);
      if (s_axis_tvalid && s_axis_tready)
        book.note_item(op_e'(s_axis_tuser), s_axis_tdata[POS_W-1:0],
                       s_axis_tdata[POS_W+END_W-1:POS_W],
                       val_t'(s_axis_tdata[POS_W+END_W+VAL_W-1:POS_W+END_W]));
    end
  end

  // One input transfer, with random idle cycles ahead of it
  task automatic send_item(op_e op, logic [POS_W-1:0] pos, logic [END_W-1:0] stop,
                           val_t v);
    while (!calm && $urandom_range(99) < 15) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {{(S_TDATA_W-POS_W-END_W-VAL_W){1'b0}}, v, stop, pos};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  function automatic val_t any_value();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    case ($urandom_range(9))
      0:       return val_t'(raw[VAL_W-1:0]);          // often past the clamp
      1:       return raw[0] ? INF_VAL : -INF_VAL;
      2:       return val_t'($signed(raw[7:0]));       // ties are likely
      default: return val_t'(raw[VAL_W-1:0]) >>> $urandom_range(50, 20);
    endcase
  endfunction

  function automatic logic [POS_W-1:0] any_position();
    return POS_W'(($urandom_range(99) < 40) ? $urandom_range(63) : $urandom_range(1023));
  endfunction

  function automatic logic [END_W-1:0] any_end(int unsigned pos);
    int unsigned stop;
    case ($urandom_range(9))
      0:       stop = $urandom_range(2047);
      1:       stop = TREE_LEAVES;
      2:       stop = pos;
      3:       stop = pos + 1 + $urandom_range(1023);
      default: stop = pos + 1 + $urandom_range(15);
    endcase
    return END_W'((stop > 2047) ? 2047 : stop);
  endfunction

  initial begin
    int unsigned  done;
    op_e          op;
    logic [POS_W-1:0] pos;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty tree, clamp limits, range edges, dropped code
    send_item(OP_READ,   0,    11'd5,    INF_VAL);
    send_item(OP_QUERY,  0,    11'd1024, '0);
    send_item(OP_UPDATE, 0,    11'd0,    -INF_VAL);
    send_item(OP_UPDATE, 1023, 11'd2047, INF_VAL);
    send_item(OP_UPDATE, 5,    11'd0,    {1'b0, {(VAL_W-1){1'b1}}});
    send_item(OP_UPDATE, 6,    11'd0,    {1'b1, {(VAL_W-1){1'b0}}});
    send_item(OP_UPDATE, 512,  11'd0,    '0);
    send_item(OP_UPDATE, 7,    11'd0,    -1);
    send_item(OP_QUERY,  0,    11'd1024, '0);
    send_item(OP_QUERY,  1,    11'd1024, '0);
    send_item(OP_QUERY,  5,    11'd7,    '0);
    send_item(OP_QUERY,  7,    11'd1024, '0);
    send_item(OP_QUERY,  1023, 11'd1024, INF_VAL);
    send_item(OP_QUERY,  7,    11'd7,    '0);
    send_item(OP_QUERY,  10,   11'd3,    '0);
    send_item(OP_QUERY,  0,    11'd0,    '0);
    send_item(OP_QUERY,  500,  11'd2047, '0);
    send_item(OP_QUERY,  1023, 11'd1500, '0);
    send_item(OP_READ,   5,    11'd0,    '0);
    send_item(OP_READ,   6,    11'd2047, '0);
    send_item(OP_READ,   1023, 11'd0,    '0);
    send_item(OP_NONE,   512,  11'd1024, -INF_VAL);
    send_item(OP_READ,   512,  11'd0,    '0);
    send_item(OP_QUERY,  8,    11'd1024, '0);

    // Random mix; a quiet stretch with no idling in the middle
    done = 0;
    while (done < RANDOM_ITEMS) begin
      calm = (done >= 400 && done < 650);
      case ($urandom_range(99)) inside
        [0:39]:  op = OP_UPDATE;
        [40:74]: op = OP_QUERY;
        [75:94]: op = OP_READ;
        default: op = OP_NONE;
      endcase
      pos = any_position();
      send_item(op, pos, any_end(pos), any_value());
      if (op != OP_NONE) done++;
    end
    calm = 1'b0;
    s_axis_tvalid <= 1'b0;

    // Drain, then allow one more item's worth of cycles
    while (book.due_minima.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    $display("Covered %0d updates, %0d queries (%0d empty), %0d reads, %0d dropped codes;",
             book.updates, book.queries, book.empties, book.reads, book.dropped);
    $display("%0d minima checked against the shadow tree.", book.checked);
    if (book.fails == 0 && book.due_minima.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  // Run limit, well beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("testbench: errors");
    $finish;
  end

endmodule

[files.f]
design/rmst_pkg.sv
design/rmst_ram.sv
design/range_minimum_segment_tree.sv
dv/testbench.sv
